// ----- rtl/ttb_pkg.sv -----
// Shared definitions for the triangle tangent/bitangent block.
// Holds the operand-select codes, corner slot codes and the command struct
// that joins the controller to the datapath. No dependencies.
`default_nettype none

package ttb_pkg;

  localparam logic [1:0] TERM_DET   = 2'd0;
  localparam logic [1:0] TERM_TAN   = 2'd1;
  localparam logic [1:0] TERM_BITAN = 2'd2;

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  localparam logic [2:0] COMP_BITAN_BASE = 3'd3;
  localparam logic [2:0] COMP_LAST       = 3'd5;

  localparam logic [1:0] EMIT_LAST = 2'd2;

  typedef struct packed {
    logic       cap_en;
    logic [1:0] cap_slot;
    logic       load;
    logic [1:0] kind;
    logic [1:0] axis;
    logic       second;
    logic       mul_lo;
    logic       mul_hi;
    logic       acc_en;
    logic       acc_first;
    logic       det_save;
    logic       res_clear;
    logic       div_start;
    logic       div_step;
    logic       div_fin;
    logic [2:0] comp;
  } ttb_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ttb_corner_if.sv -----
// Request channel that carries one triangle corner: position and texture
// coordinate in signed fixed point. No dependencies.
`default_nettype none

interface ttb_corner_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] pos_x;
  logic [W-1:0] pos_y;
  logic [W-1:0] pos_z;
  logic [W-1:0] tex_u;
  logic [W-1:0] tex_v;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output tex_u, output tex_v, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input tex_u, input tex_v, output ready);
endinterface

`default_nettype wire

// ----- rtl/ttb_result_if.sv -----
// Request channel that carries one per-corner result: tangent, bitangent
// and the degenerate and last-of-run flags. No dependencies.
`default_nettype none

interface ttb_result_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] tan_x;
  logic [W-1:0] tan_y;
  logic [W-1:0] tan_z;
  logic [W-1:0] bitan_x;
  logic [W-1:0] bitan_y;
  logic [W-1:0] bitan_z;
  logic         degenerate;
  logic         last_of_run;

  modport source (output valid, output tan_x, output tan_y, output tan_z,
                  output bitan_x, output bitan_y, output bitan_z,
                  output degenerate, output last_of_run, input ready);
  modport sink   (input valid, input tan_x, input tan_y, input tan_z,
                  input bitan_x, input bitan_y, input bitan_z,
                  input degenerate, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/ttb_datapath.sv -----
// Datapath: corner storage, delta forming, split shared multiplier with
// accumulator, and a one-bit-per-cycle restoring divider with saturation.
// Depends on ttb_pkg for the command struct and select codes.
`default_nettype none

module ttb_datapath
  import ttb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire ttb_cmd_t               cmd,
  input  wire logic [COORD_WIDTH-1:0] pos_x,
  input  wire logic [COORD_WIDTH-1:0] pos_y,
  input  wire logic [COORD_WIDTH-1:0] pos_z,
  input  wire logic [COORD_WIDTH-1:0] tex_u,
  input  wire logic [COORD_WIDTH-1:0] tex_v,
  output logic                        acc_zero,
  output logic [COORD_WIDTH-1:0]      tan_x,
  output logic [COORD_WIDTH-1:0]      tan_y,
  output logic [COORD_WIDTH-1:0]      tan_z,
  output logic [COORD_WIDTH-1:0]      bitan_x,
  output logic [COORD_WIDTH-1:0]      bitan_y,
  output logic [COORD_WIDTH-1:0]      bitan_z,
  output logic                        degenerate
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int H  = W / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 2;
  localparam int XW = 2 * W + 1;
  localparam int NW = XW + F;
  localparam int UW = NW - W;
  localparam int CW = (UW > XW) ? UW : XW;
  localparam int TEX_U = 0;
  localparam int TEX_V = 1;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] p0_r [3];
  logic [W-1:0] p1_r [3];
  logic [W-1:0] p2_r [3];
  logic [W-1:0] t0_r [2];
  logic [W-1:0] t1_r [2];
  logic [W-1:0] t2_r [2];

  logic [W-1:0]    a_min, a_sub, b_min, b_sub;
  logic [W:0]      a_d, b_d, a_abs, b_abs;
  logic            a_neg, b_neg;
  logic [W-1:0]    a_mag_r, b_mag_r;
  logic            op_neg_r;
  logic [W+H-1:0]  plo_nxt, plo_r;
  logic [W+HW-1:0] phi_nxt, phi_r;
  logic [PW-1:0]   mag_sum;
  logic [AW-1:0]   prod_u, prod_s, acc_nxt, acc_r, acc_abs;
  logic [XW-1:0]   acc_mag, det_mag_r;
  logic            det_neg_r, degen_r;

  logic [NW-1:0]   num_ext;
  logic [CW-1:0]   upper_c, den_c;
  logic [XW:0]     rem_sh, den_sh, diff;
  logic            ge;
  logic [XW-1:0]   rem_r;
  logic [W-1:0]    low_r, q_r;
  logic            ovf_r, div_neg_r;
  logic [W-1:0]    lim, sat_mag, res_nxt;
  logic [W-1:0]    res_r [6];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_slot)
        SLOT_FIRST: begin
          p0_r[0] <= pos_x; p0_r[1] <= pos_y; p0_r[2] <= pos_z;
          t0_r[TEX_U] <= tex_u; t0_r[TEX_V] <= tex_v;
        end
        SLOT_SECOND: begin
          p1_r[0] <= pos_x; p1_r[1] <= pos_y; p1_r[2] <= pos_z;
          t1_r[TEX_U] <= tex_u; t1_r[TEX_V] <= tex_v;
        end
        SLOT_THIRD: begin
          p2_r[0] <= pos_x; p2_r[1] <= pos_y; p2_r[2] <= pos_z;
          t2_r[TEX_U] <= tex_u; t2_r[TEX_V] <= tex_v;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    a_min = '0;
    a_sub = '0;
    b_min = '0;
    b_sub = '0;
    case (cmd.kind)
      TERM_DET: begin
        a_min = cmd.second ? t1_r[TEX_V] : t1_r[TEX_U];
        a_sub = cmd.second ? t0_r[TEX_V] : t0_r[TEX_U];
        b_min = cmd.second ? t2_r[TEX_U] : t2_r[TEX_V];
        b_sub = cmd.second ? t0_r[TEX_U] : t0_r[TEX_V];
      end
      TERM_TAN: begin
        a_min = cmd.second ? p2_r[cmd.axis] : p1_r[cmd.axis];
        a_sub = p0_r[cmd.axis];
        b_min = cmd.second ? t1_r[TEX_V] : t2_r[TEX_V];
        b_sub = t0_r[TEX_V];
      end
      TERM_BITAN: begin
        a_min = cmd.second ? p1_r[cmd.axis] : p2_r[cmd.axis];
        a_sub = p0_r[cmd.axis];
        b_min = cmd.second ? t2_r[TEX_U] : t1_r[TEX_U];
        b_sub = t0_r[TEX_U];
      end
      default: begin
      end
    endcase
  end

  assign a_d   = {a_min[W-1], a_min} - {a_sub[W-1], a_sub};
  assign b_d   = {b_min[W-1], b_min} - {b_sub[W-1], b_sub};
  assign a_neg = a_d[W];
  assign b_neg = b_d[W];
  assign a_abs = a_neg ? -a_d : a_d;
  assign b_abs = b_neg ? -b_d : b_d;

  assign plo_nxt = (W+H)'(a_mag_r) * (W+H)'(b_mag_r[H-1:0]);
  assign phi_nxt = (W+HW)'(a_mag_r) * (W+HW)'(b_mag_r[W-1:H]);
  assign mag_sum = PW'(plo_r) + (PW'(phi_r) << H);
  assign prod_u  = AW'(mag_sum);
  assign prod_s  = op_neg_r ? -prod_u : prod_u;
  assign acc_nxt = cmd.acc_first ? prod_s : acc_r + prod_s;

  assign acc_zero = (acc_r == '0);
  assign acc_abs  = acc_r[AW-1] ? -acc_r : acc_r;
  assign acc_mag  = acc_abs[XW-1:0];

  assign num_ext = {acc_mag, {F{1'b0}}};
  assign upper_c = CW'(num_ext[NW-1:W]);
  assign den_c   = CW'(det_mag_r);

  assign rem_sh = {rem_r, low_r[W-1]};
  assign den_sh = {1'b0, det_mag_r};
  assign ge     = (rem_sh >= den_sh);
  assign diff   = rem_sh - den_sh;

  assign lim     = div_neg_r ? LIM_NEG : LIM_POS;
  assign sat_mag = (ovf_r || (q_r > lim)) ? lim : q_r;
  assign res_nxt = div_neg_r ? -sat_mag : sat_mag;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_mag_r  <= a_abs[W-1:0];
      b_mag_r  <= b_abs[W-1:0];
      op_neg_r <= a_neg ^ b_neg ^ cmd.second;
    end
    if (cmd.mul_lo) begin
      plo_r <= plo_nxt;
    end
    if (cmd.mul_hi) begin
      phi_r <= phi_nxt;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.det_save) begin
      det_mag_r <= acc_mag;
      det_neg_r <= acc_r[AW-1];
      degen_r   <= acc_zero;
    end
    if (cmd.div_start) begin
      ovf_r     <= (upper_c >= den_c);
      rem_r     <= upper_c[XW-1:0];
      low_r     <= num_ext[W-1:0];
      q_r       <= '0;
      div_neg_r <= acc_r[AW-1] ^ det_neg_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[XW-1:0] : rem_sh[XW-1:0];
      low_r <= {low_r[W-2:0], 1'b0};
      q_r   <= {q_r[W-2:0], ge};
    end
    if (cmd.res_clear) begin
      for (int k = 0; k < 6; k++) begin
        res_r[k] <= '0;
      end
    end else if (cmd.div_fin) begin
      res_r[cmd.comp] <= res_nxt;
    end
  end

  assign tan_x      = res_r[0];
  assign tan_y      = res_r[1];
  assign tan_z      = res_r[2];
  assign bitan_x    = res_r[3];
  assign bitan_y    = res_r[4];
  assign bitan_z    = res_r[5];
  assign degenerate = degen_r;

endmodule

`default_nettype wire

// ----- rtl/ttb_ctrl.sv -----
// Controller state machine: corner counting, the product and division
// schedule for one triangle, and the three-result output sequence.
// Depends on ttb_pkg for the command struct and codes.
`default_nettype none

module ttb_ctrl
  import ttb_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic          out_last,
  input  wire logic     acc_zero,
  output ttb_cmd_t      cmd
);

  localparam int SW = $clog2(COORD_WIDTH);
  localparam logic [SW-1:0] STEP_LAST = SW'(COORD_WIDTH - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_MLO    = 4'd2;
  localparam logic [3:0] S_MHI    = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_DET    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DSTEP  = 4'd7;
  localparam logic [3:0] S_DFIN   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [2:0]    comp_r, comp_nxt;
  logic          second_r, second_nxt;
  logic          det_phase_r, det_phase_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [1:0]    emit_r, emit_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    comp_nxt      = comp_r;
    second_nxt    = second_r;
    det_phase_nxt = det_phase_r;
    step_nxt      = step_r;
    emit_nxt      = emit_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    out_last      = (emit_r == EMIT_LAST);

    cmd.second = second_r;
    cmd.comp   = comp_r;
    if (det_phase_r) begin
      cmd.kind = TERM_DET;
      cmd.axis = 2'd0;
    end else if (comp_r < COMP_BITAN_BASE) begin
      cmd.kind = TERM_TAN;
      cmd.axis = comp_r[1:0];
    end else begin
      cmd.kind = TERM_BITAN;
      cmd.axis = 2'(comp_r - COMP_BITAN_BASE);
    end
    cmd.cap_slot = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_en = 1'b1;
          if (cnt_r == SLOT_THIRD) begin
            cnt_nxt       = SLOT_FIRST;
            det_phase_nxt = 1'b1;
            second_nxt    = 1'b0;
            state_nxt     = S_LOAD;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = !second_r;
        if (!second_r) begin
          second_nxt = 1'b1;
          state_nxt  = S_LOAD;
        end else begin
          second_nxt = 1'b0;
          state_nxt  = det_phase_r ? S_DET : S_DSTART;
        end
      end
      S_DET: begin
        cmd.det_save  = 1'b1;
        det_phase_nxt = 1'b0;
        comp_nxt      = 3'd0;
        if (acc_zero) begin
          cmd.res_clear = 1'b1;
          emit_nxt      = 2'd0;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_DFIN;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        if (comp_r == COMP_LAST) begin
          emit_nxt  = 2'd0;
          state_nxt = S_EMIT;
        end else begin
          comp_nxt  = comp_r + 3'd1;
          state_nxt = S_LOAD;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        in_ready  = (cnt_r != SLOT_THIRD);
        if (in_valid && (cnt_r != SLOT_THIRD)) begin
          cmd.cap_en = 1'b1;
          cnt_nxt    = cnt_r + 2'd1;
        end
        if (out_ready) begin
          if (emit_r == EMIT_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= SLOT_FIRST;
      comp_r      <= 3'd0;
      second_r    <= 1'b0;
      det_phase_r <= 1'b0;
      step_r      <= '0;
      emit_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      second_r    <= second_nxt;
      det_phase_r <= det_phase_nxt;
      step_r      <= step_nxt;
      emit_r      <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/triangle_tangent_bitangent_top.sv -----
// Per-triangle tangent and bitangent from texture coordinates.
// Corners enter on in_if, one request per corner; after every third corner
// three identical results leave on out_if, the third marked last_of_run.
// Both channels move a request at a clock edge where valid and ready are high.
// After the third corner is taken, results are computed on one shared
// multiplier, used in two halves per product for 14 products (two when the
// texture determinant is zero), and one restoring divider that retires one
// quotient bit per cycle for each of the six components.
// The first two corners of the next triangle are taken while results wait.
// When the receiver stalls, the current result holds on out_if and the third
// corner of the next triangle is refused until the last result leaves.
// A zero texture determinant gives zero vectors with degenerate set; other
// results saturate to the signed range.
// Reset (rst_n low, synchronous) clears the corner count and the sequencer.
// Depends on ttb_pkg, ttb_corner_if, ttb_result_if, ttb_ctrl, ttb_datapath.
`default_nettype none

module triangle_tangent_bitangent_top
  import ttb_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ttb_corner_if.sink    in_if,
  ttb_result_if.source  out_if
);

  ttb_cmd_t cmd;
  logic     acc_zero;

  ttb_ctrl #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_last  (out_if.last_of_run),
    .acc_zero  (acc_zero),
    .cmd       (cmd)
  );

  ttb_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .pos_x      (in_if.pos_x),
    .pos_y      (in_if.pos_y),
    .pos_z      (in_if.pos_z),
    .tex_u      (in_if.tex_u),
    .tex_v      (in_if.tex_v),
    .acc_zero   (acc_zero),
    .tan_x      (out_if.tan_x),
    .tan_y      (out_if.tan_y),
    .tan_z      (out_if.tan_z),
    .bitan_x    (out_if.bitan_x),
    .bitan_y    (out_if.bitan_y),
    .bitan_z    (out_if.bitan_z),
    .degenerate (out_if.degenerate)
  );

endmodule

`default_nettype wire

// ----- tb/tb_triangle_tangent_bitangent_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for triangle_tangent_bitangent_top: drives corners with random
// gaps and result stalls, predicts each tangent frame in fixed point and checks every result.
// Depends on ttb_corner_if, ttb_result_if and the block's RTL.

module tb_triangle_tangent_bitangent_top;

  localparam int W = 32;
  localparam int FRAC = 16;
  localparam int RESULT_LATENCY = 6 * W + 69;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [W-1:0] Q_ONE = 32'h0001_0000;

  typedef struct {
    logic signed [W-1:0] pos[3];
    logic signed [W-1:0] tex[2];
  } corner_t;

  typedef struct {
    logic [W-1:0] tan[3];
    logic [W-1:0] bitan[3];
    logic         degenerate;
    logic         last_of_run;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;

  ttb_corner_if #(.W(W)) in_if ();
  ttb_result_if #(.W(W)) out_if ();

  triangle_tangent_bitangent_top #(
    .COORD_WIDTH(W),
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if)
  );

  always #10 clk = ~clk;

  frame_t pending_frames[$];
  corner_t first_corner;
  corner_t second_corner;
  int corners_held = 0;
  int errors = 0;
  int ready_hold = 0;
  int idle_cycles = 0;
  bit corner_gaps = 1'b1;
  bit result_stalls = 1'b1;
  bit result_taken = 1'b0;

  function automatic logic signed [127:0] widen(logic signed [W-1:0] v);
    return v;
  endfunction

  function automatic logic [W-1:0] scaled_quotient(logic signed [127:0] num,
                                                   logic signed [127:0] den);
    logic neg;
    logic [127:0] mag_n;
    logic [127:0] mag_d;
    logic [127:0] q;
    logic [127:0] lim;
    logic [W-1:0] mag;
    neg = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    q = (mag_n << FRAC) / mag_d;
    lim = neg ? (128'd1 << (W - 1)) : (128'd1 << (W - 1)) - 128'd1;
    if (q > lim) q = lim;
    mag = q[W-1:0];
    return neg ? -mag : mag;
  endfunction

  function automatic frame_t predict_frame(corner_t a, corner_t b, corner_t c);
    frame_t f;
    logic signed [127:0] du1, dv1, du2, dv2, det, dp1, dp2;
    du1 = widen(b.tex[0]) - widen(a.tex[0]);
    dv1 = widen(b.tex[1]) - widen(a.tex[1]);
    du2 = widen(c.tex[0]) - widen(a.tex[0]);
    dv2 = widen(c.tex[1]) - widen(a.tex[1]);
    det = du1 * dv2 - dv1 * du2;
    f.degenerate = (det == 0);
    f.last_of_run = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dp1 = widen(b.pos[i]) - widen(a.pos[i]);
      dp2 = widen(c.pos[i]) - widen(a.pos[i]);
      if (det == 0) begin
        f.tan[i] = '0;
        f.bitan[i] = '0;
      end else begin
        f.tan[i] = scaled_quotient(dp1 * dv2 - dp2 * dv1, det);
        f.bitan[i] = scaled_quotient(dp2 * du1 - dp1 * du2, det);
      end
    end
    return f;
  endfunction

  function automatic corner_t make_corner(logic [W-1:0] px, logic [W-1:0] py,
                                          logic [W-1:0] pz, logic [W-1:0] u,
                                          logic [W-1:0] v);
    corner_t c;
    c.pos[0] = px;
    c.pos[1] = py;
    c.pos[2] = pz;
    c.tex[0] = u;
    c.tex[1] = v;
    return c;
  endfunction

  function automatic int draw_wait(bit enabled);
    return enabled ? int'($urandom_range(0, 15)) : 0;
  endfunction

  function automatic logic [W-1:0] draw_coord(int unsigned style);
    int signed value;
    case (style)
      0: value = $urandom;
      1: value = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      2: begin
        case ($urandom_range(0, 5))
          0: value = Q_MAX;
          1: value = Q_MIN;
          2: value = 0;
          3: value = -1;
          4: value = 1;
          default: value = Q_ONE;
        endcase
      end
      default: value = (int'($urandom_range(0, 8)) - 4) <<< FRAC;
    endcase
    return value;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic accept_corner(corner_t c);
    frame_t f;
    case (corners_held)
      0: begin
        first_corner = c;
        corners_held = 1;
      end
      1: begin
        second_corner = c;
        corners_held = 2;
      end
      default: begin
        f = predict_frame(first_corner, second_corner, c);
        for (int k = 0; k < 3; k++) begin
          f.last_of_run = (k == 2);
          pending_frames = {pending_frames, f};
        end
        corners_held = 0;
      end
    endcase
  endtask

  task automatic send_corner(corner_t c);
    int gap;
    gap = draw_wait(corner_gaps);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.pos_x <= c.pos[0];
    in_if.pos_y <= c.pos[1];
    in_if.pos_z <= c.pos[2];
    in_if.tex_u <= c.tex[0];
    in_if.tex_v <= c.tex[1];
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    accept_corner(c);
  endtask

  task automatic send_triangle(corner_t a, corner_t b, corner_t c);
    send_corner(a);
    send_corner(b);
    send_corner(c);
  endtask

  // With unit texture edges (first triangle) the tangent equals the first position
  // edge and the bitangent the second one; the second triangle has non-unit edges.
  task automatic test_unit_uv();
    send_triangle(make_corner(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0),
                  make_corner(32'h0001_8000, 32'hFFFE_0000, 32'h0007_0000, Q_ONE, 0),
                  make_corner(32'hFFFC_0000, 32'h0000_4000, 32'h0003_0000, 0, Q_ONE));
    send_triangle(make_corner(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001,
                              32'h0002_0000, 32'h0000_8000),
                  make_corner(32'h0000_0000, 32'h0101_0101, 32'h8765_4321,
                              32'h0000_8000, 32'h0002_0000),
                  make_corner(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_0000,
                              32'h0003_0000, 32'hFFFF_0000));
  endtask

  task automatic test_degenerate();
    send_triangle(make_corner(0, 0, 0, 0, 0), make_corner(0, 0, 0, 0, 0),
                  make_corner(0, 0, 0, 0, 0));
    send_triangle(make_corner(Q_MAX, Q_MIN, Q_ONE, 32'h0001_0000, 32'h0002_0000),
                  make_corner(Q_MIN, Q_MAX, 0, 32'h0002_0000, 32'h0003_0000),
                  make_corner(32'h5555_5555, 32'hAAAA_AAAA, Q_MIN,
                              32'h0004_0000, 32'h0005_0000));
  endtask

  // A determinant of one or minus one least significant bit drives the
  // components past both signed bounds.
  task automatic test_saturation();
    send_triangle(make_corner(0, 0, 0, 0, 0),
                  make_corner(Q_MAX, Q_MIN, 32'd1, 32'd1, 0),
                  make_corner(Q_MIN, Q_MAX, 0, 0, 32'd1));
    send_triangle(make_corner(0, 0, 0, 0, 0),
                  make_corner(Q_MAX, Q_MIN, 32'd1, 0, 32'd1),
                  make_corner(Q_MIN, Q_MAX, 0, 32'd1, 0));
  endtask

  task automatic test_extremes();
    send_triangle(make_corner(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
                  make_corner(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                  make_corner(0, 0, 0, Q_MIN, Q_MAX));
    send_triangle(make_corner(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                  make_corner(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN),
                  make_corner(32'hFFFF_FFFF, 32'd1, Q_MIN, 32'hFFFF_FFFF, Q_ONE));
  endtask

  task automatic test_random();
    corner_t c[3];
    int unsigned style;
    int unsigned shape;
    for (int t = 0; t < 100; t++) begin
      if (t % 10 == 0) begin
        corner_gaps = ($urandom_range(0, 3) != 0);
        result_stalls = ($urandom_range(0, 3) != 0);
      end
      style = $urandom_range(0, 3);
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++)
          c[k].pos[i] = draw_coord(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : style);
        for (int i = 0; i < 2; i++)
          c[k].tex[i] = draw_coord(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : style);
      end
      if (shape == 0) begin
        c[2].tex = c[$urandom_range(0, 1)].tex;
      end else if (shape == 1) begin
        for (int i = 0; i < 2; i++)
          c[2].tex[i] = c[0].tex[i] + 2 * (c[1].tex[i] - c[0].tex[i]);
      end
      send_triangle(c[0], c[1], c[2]);
    end
  endtask

  always @(posedge clk) begin
    frame_t seen;
    frame_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.tan[0] = out_if.tan_x;
      seen.tan[1] = out_if.tan_y;
      seen.tan[2] = out_if.tan_z;
      seen.bitan[0] = out_if.bitan_x;
      seen.bitan[1] = out_if.bitan_y;
      seen.bitan[2] = out_if.bitan_z;
      seen.degenerate = out_if.degenerate;
      seen.last_of_run = out_if.last_of_run;
      if (pending_frames.size() == 0) begin
        report_mismatch("result arrived with no request pending");
      end else begin
        want = pending_frames.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (seen.tan[i] !== want.tan[i])
            report_mismatch($sformatf("tan[%0d] got %h want %h", i, seen.tan[i], want.tan[i]));
          if (seen.bitan[i] !== want.bitan[i])
            report_mismatch($sformatf("bitan[%0d] got %h want %h", i, seen.bitan[i],
                                      want.bitan[i]));
        end
        if (seen.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate got %b want %b", seen.degenerate,
                                    want.degenerate));
        if (seen.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %b want %b", seen.last_of_run,
                                    want.last_of_run));
      end
    end
    result_taken <= (rst_n && out_if.valid && out_if.ready);
  end

  always @(negedge clk) begin
    if (result_taken) begin
      ready_hold = draw_wait(result_stalls);
    end
    if (!rst_n || (ready_hold > 0)) begin
      out_if.ready <= 1'b0;
      if (ready_hold > 0) begin
        ready_hold = ready_hold - 1;
      end
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results pending", $time,
               pending_frames.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.tex_u = '0;
    in_if.tex_v = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_unit_uv();
    test_degenerate();
    test_saturation();
    test_extremes();
    test_random();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 40) @(posedge clk);
    foreach (pending_frames[i])
      report_mismatch("expected result never arrived");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ttb_pkg.sv
rtl/ttb_corner_if.sv
rtl/ttb_result_if.sv
rtl/ttb_datapath.sv
rtl/ttb_ctrl.sv
rtl/triangle_tangent_bitangent_top.sv
tb/tb_triangle_tangent_bitangent_top.sv
